/* rtl/min_heap_priority_queue_top_defines.svh */
// Assertion macros used by the min-heap priority queue controller.
`ifndef MIN_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define MIN_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MHPQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MHPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/mhpq_pkg.sv */
// Types and constants of the min-heap priority queue.
package mhpq_pkg;

    localparam int KEY_W   = 32;
    localparam int COUNT_W = 7;

    localparam logic [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_OVERFLOW = 2'd1,
        STAT_EMPTY    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_CMP,
        ST_EX_LOAD,
        ST_DN_CMP,
        ST_WR_KEY,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic signed [KEY_W-1:0] value;
        t_status                 status;
        logic [COUNT_W-1:0]      entry_count;
    } t_result;

endpackage

/* rtl/mhpq_ram.sv */
// Generic synchronous RAM with one write port and two registered read ports.
module mhpq_ram
    #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
    )
    (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
    );

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

/* rtl/mhpq_ctrl.sv */
// Heap controller: sift-up and sift-down sequencer around the heap memory.
`include "min_heap_priority_queue_top_defines.svh"

module mhpq_ctrl
    import mhpq_pkg::*;
    #(
    parameter int CAPACITY = 64
    )
    (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_opcode,
    input  logic signed [KEY_W-1:0]       i_key,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output t_result                       o_res,
    output logic                          o_mem_we,
    output logic [$clog2(CAPACITY)-1:0]   o_mem_waddr,
    output logic [KEY_W-1:0]              o_mem_wdata,
    output logic [$clog2(CAPACITY)-1:0]   o_mem_raddr_a,
    output logic [$clog2(CAPACITY)-1:0]   o_mem_raddr_b,
    input  logic signed [KEY_W-1:0]       i_mem_rdata_a,
    input  logic signed [KEY_W-1:0]       i_mem_rdata_b
    );

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [AW-1:0]           r_pos, n_pos;
    logic signed [KEY_W-1:0] r_key, n_key;
    t_result                 r_res, n_res;

    logic          w_acc, w_ins, w_full, w_empty;
    logic [AW-1:0] w_ins_pos, w_ins_par, w_up_par, w_last;
    logic          w_up_move, w_up_root;
    logic [IW-1:0] w_lc, w_rc, w_nlc;
    logic          w_l_less, w_r_less, w_dn_move, w_dn_more;
    logic signed [KEY_W-1:0] w_best_val;
    logic [AW-1:0] w_best_idx;

    assign w_acc     = i_in_valid && o_in_ready;
    assign w_ins     = (i_opcode == OP_INSERT);
    assign w_full    = (r_count == CW'(CAPACITY));
    assign w_empty   = (r_count == '0);
    assign w_ins_pos = AW'(r_count);
    assign w_ins_par = (w_ins_pos - AW'(1)) >> 1;
    assign w_last    = AW'(r_count - CW'(1));

    // Sift-up: the moving key stays in r_key; the hole at r_pos takes the parent.
    assign w_up_par  = (r_pos - AW'(1)) >> 1;
    assign w_up_move = (r_key < i_mem_rdata_a);
    assign w_up_root = (w_up_par == '0);

    // Sift-down: both children are read together; a child wins only if strictly smaller.
    assign w_lc       = IW'({r_pos, 1'b1});
    assign w_rc       = w_lc + IW'(1);
    assign w_l_less   = (i_mem_rdata_a < r_key);
    assign w_best_val = w_l_less ? i_mem_rdata_a : r_key;
    assign w_r_less   = (w_rc < IW'(r_count)) && (i_mem_rdata_b < w_best_val);
    assign w_dn_move  = w_l_less || w_r_less;
    assign w_best_idx = w_r_less ? AW'(w_rc) : AW'(w_lc);
    assign w_nlc      = IW'({w_best_idx, 1'b1});
    assign w_dn_more  = (w_nlc < IW'(r_count));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    if (w_ins) begin
                        n_state = (w_full || w_empty) ? ST_OUT : ST_UP_CMP;
                    end else begin
                        n_state = w_empty ? ST_OUT : ST_EX_LOAD;
                    end
                end
            end
            ST_UP_CMP: begin
                if (!w_up_move) begin
                    n_state = ST_OUT;
                end else if (w_up_root) begin
                    n_state = ST_WR_KEY;
                end
            end
            ST_EX_LOAD: begin
                n_state = (r_count > CW'(1)) ? ST_DN_CMP : ST_OUT;
            end
            ST_DN_CMP: begin
                if (!w_dn_move) begin
                    n_state = ST_OUT;
                end else if (!w_dn_more) begin
                    n_state = ST_WR_KEY;
                end
            end
            ST_WR_KEY: n_state = ST_OUT;
            ST_OUT: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs: handshake and memory port control.
    always_comb begin
        o_in_ready    = 1'b0;
        o_res_valid   = 1'b0;
        o_mem_we      = 1'b0;
        o_mem_waddr   = r_pos;
        o_mem_wdata   = r_key;
        o_mem_raddr_a = '0;
        o_mem_raddr_b = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_mem_raddr_a = w_ins ? w_ins_par : '0;
                o_mem_raddr_b = w_last;
                if (w_acc && w_ins && w_empty) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = '0;
                    o_mem_wdata = i_key;
                end
            end
            ST_UP_CMP: begin
                o_mem_we      = 1'b1;
                o_mem_raddr_a = (w_up_par - AW'(1)) >> 1;
                if (w_up_move) begin
                    o_mem_wdata = i_mem_rdata_a;
                end
            end
            ST_EX_LOAD: begin
                o_mem_raddr_a = AW'(1);
                o_mem_raddr_b = AW'(2 % CAPACITY);
                // With one key left the moved entry lands at the root directly.
                if (r_count == CW'(1)) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = '0;
                    o_mem_wdata = i_mem_rdata_b;
                end
            end
            ST_DN_CMP: begin
                o_mem_we      = 1'b1;
                o_mem_raddr_a = AW'(w_nlc);
                o_mem_raddr_b = AW'(w_nlc + IW'(1));
                if (w_dn_move) begin
                    o_mem_wdata = w_r_less ? i_mem_rdata_b : i_mem_rdata_a;
                end
            end
            ST_WR_KEY: o_mem_we = 1'b1;
            ST_OUT:    o_res_valid = 1'b1;
            default: ;
        endcase
    end

    // Datapath registers.
    always_comb begin
        n_count = r_count;
        n_pos   = r_pos;
        n_key   = r_key;
        n_res   = r_res;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    if (w_ins) begin
                        n_key       = i_key;
                        n_pos       = w_ins_pos;
                        n_res.value = '0;
                        if (w_full) begin
                            n_res.status      = STAT_OVERFLOW;
                            n_res.entry_count = COUNT_W'(r_count);
                        end else begin
                            n_count           = r_count + CW'(1);
                            n_res.status      = STAT_OK;
                            n_res.entry_count = COUNT_W'(r_count + CW'(1));
                        end
                    end else if (w_empty) begin
                        n_res.value       = KEY_MAX;
                        n_res.status      = STAT_EMPTY;
                        n_res.entry_count = '0;
                    end else begin
                        n_count           = r_count - CW'(1);
                        n_res.status      = STAT_OK;
                        n_res.entry_count = COUNT_W'(r_count - CW'(1));
                    end
                end
            end
            ST_UP_CMP: begin
                if (w_up_move) begin
                    n_pos = w_up_par;
                end
            end
            ST_EX_LOAD: begin
                n_res.value = i_mem_rdata_a;
                n_key       = i_mem_rdata_b;
                n_pos       = '0;
            end
            ST_DN_CMP: begin
                if (w_dn_move) begin
                    n_pos = w_best_idx;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_key <= n_key;
        r_res <= n_res;
    end

    assign o_res = r_res;

    `MHPQ_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY), "entry count above capacity")
    `MHPQ_ASSERT_NEXT(a_ins_count, i_clk, i_rst_n, w_acc && w_ins && !w_full, r_count == $past(r_count) + CW'(1), "insert did not grow the count")
    `MHPQ_ASSERT_IMPLY(a_dn_child, i_clk, i_rst_n, r_state == ST_DN_CMP, w_lc < IW'(r_count), "sift-down hole has no child")
    `MHPQ_ASSERT_IMPLY(a_ovf_full, i_clk, i_rst_n, o_res_valid && (r_res.status == STAT_OVERFLOW), r_count == CW'(CAPACITY), "overflow reported below capacity")

endmodule

/* rtl/min_heap_priority_queue_top.sv */
// Binary min-heap priority queue of signed 32-bit keys.
//
// Input channel (i_in_valid/o_in_ready) carries i_opcode and i_key: an insert
// of i_key or an extract of the smallest key. Each transaction yields exactly
// one result transaction (o_out_valid/i_out_ready) with o_result_value,
// o_status and o_entry_count, the number of keys held afterwards.
// An insert on a full heap is dropped with overflow status; an extract on an
// empty heap returns the largest integer with empty status.
// An insert on an empty or full heap and an extract on an empty heap are the
// fastest operations. At each heap level the heap memory reads the parent or
// both children while the previous level's compare writes back the hole. A new
// item can be taken in the cycle after the result enters the output register.
// Reset clears the entry count; heap contents need no clearing.
// When the receiver stalls, the result waits in the output register and one
// further item can be processed; its result then waits inside the controller,
// which takes no new item until the output register frees up.
module min_heap_priority_queue_top
    import mhpq_pkg::*;
    #(
    parameter int CAPACITY = 64
    )
    (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_opcode,
    input  logic signed [KEY_W-1:0] i_key,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [KEY_W-1:0] o_result_value,
    output logic [1:0]              o_status,
    output logic [COUNT_W-1:0]      o_entry_count
    );

    localparam int AW = $clog2(CAPACITY);

    logic          w_res_valid, w_res_ready;
    t_result       w_res;
    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr_a, w_raddr_b;
    logic [KEY_W-1:0] w_wdata, w_rdata_a, w_rdata_b;

    logic    r_out_valid;
    t_result r_out;

    mhpq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_key         (i_key),
        .o_res_valid   (w_res_valid),
        .i_res_ready   (w_res_ready),
        .o_res         (w_res),
        .o_mem_we      (w_we),
        .o_mem_waddr   (w_waddr),
        .o_mem_wdata   (w_wdata),
        .o_mem_raddr_a (w_raddr_a),
        .o_mem_raddr_b (w_raddr_b),
        .i_mem_rdata_a ($signed(w_rdata_a)),
        .i_mem_rdata_b ($signed(w_rdata_b))
    );

    mhpq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    // Output register frees up in the same cycle its transaction completes.
    assign w_res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out.value;
    assign o_status       = r_out.status;
    assign o_entry_count  = r_out.entry_count;

endmodule
